/* rtl/b64e_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the symbol-to-ascii mapping of the encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

	// one input word: a message byte and its end-of-message mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} byte_word_t;

	// one output word: an ascii character and its end-of-stream flag
	typedef struct packed {
		logic [7:0] ascii_char;
		logic       end_of_stream;
	} char_word_t;

	localparam int unsigned SLOTS = 4;
	localparam int unsigned SYM_W = 6;

	// classified work for one byte: up to four characters
	typedef struct packed {
		logic [SLOTS-1:0][SYM_W-1:0] sym;
		logic [SLOTS-1:0]            pad;
		logic [1:0]                  last_idx;
		logic                        fin;
	} b64e_entry_t;

	// position inside the three-byte group
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2,
		PH_UNUSED = 2'd3
	} b64e_phase_t;

	localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
	localparam logic [7:0] UPPER_BASE = 8'h41; // 'A'
	localparam logic [7:0] LOWER_BASE = 8'h61; // 'a'
	localparam logic [7:0] DIGIT_BASE = 8'h30; // '0'
	localparam logic [7:0] PLUS_CHAR  = 8'h2B; // '+'
	localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'
	localparam logic [5:0] SYM_LOWER  = 6'd26;
	localparam logic [5:0] SYM_DIGIT  = 6'd52;
	localparam logic [5:0] SYM_PLUS   = 6'd62;
	localparam logic [5:0] SYM_SLASH  = 6'd63;

	// standard alphabet lookup
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < SYM_LOWER) begin
			c = UPPER_BASE + {2'b00, v};
		end else if (v < SYM_DIGIT) begin
			c = LOWER_BASE + {2'b00, v - SYM_LOWER};
		end else if (v < SYM_PLUS) begin
			c = DIGIT_BASE + {2'b00, v - SYM_DIGIT};
		end else if (v == SYM_PLUS) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/b64e_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// takes message bytes, tracks the group phase and builds the symbol entry
// ----------------------------------------------------------------------------
module b64e_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire b64e_pkg::byte_word_t byte_word,
	input  wire logic                 q_full,
	output logic                      push,
	output b64e_pkg::b64e_entry_t     entry
);
	import b64e_pkg::*;

	b64e_phase_t phase_q, phase_d;
	logic [3:0]  leftover_q, leftover_d;
	logic [7:0]  b;

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;
	assign b          = byte_word.data_byte;

	always_comb begin
		entry       = '0;
		entry.fin   = byte_word.is_final;
		phase_d     = PH_START;
		leftover_d  = '0;
		case (phase_q)
			PH_ONE: begin
				entry.sym[0] = {leftover_q[1:0], b[7:4]};
				if (byte_word.is_final) begin
					entry.sym[1]    = {b[3:0], 2'b00};
					entry.pad[2]    = 1'b1;
					entry.last_idx  = 2'd2;
				end else begin
					entry.last_idx  = 2'd0;
					leftover_d      = b[3:0];
					phase_d         = PH_TWO;
				end
			end
			PH_TWO: begin
				entry.sym[0]   = {leftover_q, b[7:6]};
				entry.sym[1]   = b[5:0];
				entry.last_idx = 2'd1;
			end
			default: begin
				// start of a group; the unused code behaves the same
				entry.sym[0] = b[7:2];
				if (byte_word.is_final) begin
					entry.sym[1]   = {b[1:0], 4'b0000};
					entry.pad[2]   = 1'b1;
					entry.pad[3]   = 1'b1;
					entry.last_idx = 2'd3;
				end else begin
					entry.last_idx = 2'd0;
					leftover_d     = {2'b00, b[1:0]};
					phase_d        = PH_ONE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			leftover_q <= '0;
		end else if (push) begin
			phase_q    <= phase_d;
			leftover_q <= leftover_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/b64e_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// two-entry queue of symbol entries between front and back
// ----------------------------------------------------------------------------
module b64e_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b64e_pkg::b64e_entry_t wr_entry,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       not_empty,
	output b64e_pkg::b64e_entry_t      rd_entry
);
	import b64e_pkg::*;

	b64e_entry_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_entry  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/b64e_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// walks the slots of the head entry, one character a cycle while char_stall is
// low, into the output register
// ----------------------------------------------------------------------------
module b64e_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire b64e_pkg::b64e_entry_t head,
	output logic                       pop,
	output logic                       char_valid,
	input  wire logic                  char_stall,
	output b64e_pkg::char_word_t       char_word
);
	import b64e_pkg::*;

	logic [1:0]  slot_q;
	logic        valid_q;
	char_word_t  word_q;
	logic        load;
	logic        at_last;
	char_word_t  next_word;

	assign load    = head_valid && (!valid_q || !char_stall);
	assign at_last = (slot_q == head.last_idx);
	assign pop     = load && at_last;

	always_comb begin
		next_word.ascii_char    = head.pad[slot_q] ? PAD_CHAR : b64_char(head.sym[slot_q]);
		next_word.end_of_stream = head.fin && at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			slot_q  <= at_last ? 2'd0 : slot_q + 2'd1;
		end else if (!char_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

	assign char_valid = valid_q;
	assign char_word  = word_q;

endmodule
`default_nettype wire

/* rtl/base64_stream_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// usage
//   byte channel (byte_valid / byte_stall / byte_word): one message byte per
//   word, is_final set on the last byte of a message; a word is taken at an
//   edge with byte_valid high and byte_stall low
//   char channel (char_valid / char_stall / char_word): one ascii character
//   per word, end_of_stream set on the last character of a message
//   path: a taken byte is written into the queue, and its first character is
//   then loaded from the queue head into the output register on char_word
//   throughput: the output register gives one character per cycle while
//   char_stall is low; a byte makes one or two characters (four at most on a
//   final byte), so byte intake inside a group is bounded by that register
//   a two-entry queue sits between the byte side and the character side, so
//   a byte is taken while earlier characters still wait
//   reset: clears the group phase, the queue and the output valid; the next
//   byte starts a fresh message
//   receiver stall: the character holds; once the queue fills, byte_stall
//   rises until the last character of the oldest queued byte is loaded
// ----------------------------------------------------------------------------
module base64_stream_encoder (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire b64e_pkg::byte_word_t byte_word,
	output logic                      char_valid,
	input  wire logic                 char_stall,
	output b64e_pkg::char_word_t      char_word
);
	import b64e_pkg::*;

	// front to queue
	logic        push;
	b64e_entry_t wr_entry;
	logic        q_full;
	// queue to back
	logic        pop;
	logic        q_not_empty;
	b64e_entry_t rd_entry;

	// classify each byte by group phase into up to four symbols
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.q_full     (q_full),
		.push       (push),
		.entry      (wr_entry)
	);

	// decouples byte intake from character output
	b64e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_entry  (rd_entry)
	);

	// map symbols to ascii one per cycle while char_stall is low, with end-of-stream on the last
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (rd_entry),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word)
	);

endmodule
`default_nettype wire

/* rtl/b64e_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_checker
// port-level checks of the encoder, bound to the top level
// ----------------------------------------------------------------------------
module b64e_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 char_valid,
	input wire logic                 char_stall,
	input wire b64e_pkg::char_word_t char_word
);
	import b64e_pkg::*;

	// a stalled character stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid)
		else $error("char_valid dropped while stalled");

	// a stalled character does not change
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> $stable(char_word))
		else $error("char_word changed while stalled");

	// nothing is offered right after reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !char_valid)
		else $error("char_valid high right after reset");

	// a padding character that does not end the stream is followed at once by
	// the closing padding character
	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (char_word.ascii_char == PAD_CHAR) &&
		!char_word.end_of_stream
		|=> char_valid && (char_word.ascii_char == PAD_CHAR) && char_word.end_of_stream)
		else $error("padding pair broken");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_word  (char_word)
);
`default_nettype wire
